### src/cgsad_pkg.sv
// cgsad_pkg: shared types, widths and constants for the coverage gate and
// sad template match block; no dependencies
`default_nettype none
package cgsad_pkg;

	localparam int PIX_W  = 8;
	localparam int SEL_W  = 2;
	localparam int IDX_W  = 14;
	localparam int CNT_W  = 15;
	localparam int SUM_W  = 22;
	localparam int PROD_W = 26;
	localparam int PCT_W  = 11;
	localparam int RCNT_W = 3;
	localparam int MASK_W = 4;

	localparam int CFG_AW = 5;
	localparam int CFG_DW = 32;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_FRAME = 1'b1;

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
	localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};
	localparam logic [PCT_W-1:0] PCT_FULL  = 11'd1600;

	localparam logic [PIX_W-1:0]  BIN_THR_RST    = 8'd127;
	localparam logic [PCT_W-1:0]  COV_THR_RST    = 11'd80;
	localparam logic [CNT_W-1:0]  REGION_RST     = 15'd16384;
	localparam logic [RCNT_W-1:0] REF_COUNT_RST  = 3'd4;
	localparam logic [MASK_W-1:0] VALID_MASK_RST = 4'd3;

	typedef enum logic [2:0] {
		REG_BIN_THR    = 3'd0,
		REG_COV_THR    = 3'd1,
		REG_REGION     = 3'd2,
		REG_REF_COUNT  = 3'd3,
		REG_VALID_MASK = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [PIX_W-1:0]  bin_thr;
		logic [PCT_W-1:0]  cov_thr;
		logic [CNT_W-1:0]  region;
		logic [RCNT_W-1:0] ref_count;
		logic [MASK_W-1:0] valid_mask;
	} cgsad_cfg_t;

	// slot 0 always takes part; a count of zero acts as one
	function automatic logic slot_enabled(input int unsigned slot,
			input logic [RCNT_W-1:0] count);
		return (slot == 0) || (slot < 32'(count));
	endfunction

endpackage
`default_nettype wire

### src/cgsad_pix_if.sv
// cgsad_pix_if: input pixel channel, valid/ready with pixel payload
// depends on cgsad_pkg
`default_nettype none
interface cgsad_pix_if import cgsad_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             kind;
	logic [SEL_W-1:0] reference_select;
	logic [IDX_W-1:0] pixel_index;
	logic [PIX_W-1:0] pixel_value;
	logic             last_pixel;

	modport source (output valid, kind, reference_select, pixel_index, pixel_value,
		last_pixel, input ready);
	modport sink (input valid, kind, reference_select, pixel_index, pixel_value,
		last_pixel, output ready);
endinterface
`default_nettype wire

### src/cgsad_res_if.sv
// cgsad_res_if: result channel, valid/ready with per-frame match result
// depends on cgsad_pkg
`default_nettype none
interface cgsad_res_if import cgsad_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             detected;
	logic [CNT_W-1:0] white_count;
	logic [SEL_W-1:0] best_reference;
	logic [SUM_W-1:0] best_score;
	logic             valid_position;

	modport source (output valid, detected, white_count, best_reference, best_score,
		valid_position, input ready);
	modport sink (input valid, detected, white_count, best_reference, best_score,
		valid_position, output ready);
endinterface
`default_nettype wire

### src/coverage_gate_and_sad_template_match.sv
// coverage_gate_and_sad_template_match: top level of the coverage gate and
// sad template match block; one pixel beat accepted per cycle while fewer
// than QDEPTH frames are pending, loads and frame pixels alike; a frame
// result passes through the reference ram read, the summary queue and the
// registered minimum tree after its last pixel is accepted.
// reset clears control state and registers; the reference store holds
// nothing until loaded, with no clearing pass
`default_nettype none
module coverage_gate_and_sad_template_match import cgsad_pkg::*; #(
	parameter int REGION_MAX_PIXELS = 16384,
	parameter int REFERENCE_SLOTS   = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	cgsad_pix_if.sink              pix,
	cgsad_res_if.source            res,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [CFG_AW-1:0] paddr,
	input  wire logic [CFG_DW-1:0] pwdata,
	output logic      [CFG_DW-1:0] prdata,
	output logic                   pready
);

	localparam int QW = REFERENCE_SLOTS * SUM_W + CNT_W;

	cgsad_cfg_t    cfg;
	logic          q_push;
	logic          q_pop;
	logic          q_empty;
	logic [QW-1:0] q_data;
	logic [QW-1:0] q_head;

	cgsad_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cgsad_front #(
		.REGION_MAX_PIXELS (REGION_MAX_PIXELS),
		.REFERENCE_SLOTS   (REFERENCE_SLOTS)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix),
		.cfg    (cfg),
		.q_pop  (q_pop),
		.q_push (q_push),
		.q_data (q_data)
	);

	cgsad_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.pop       (q_pop),
		.empty     (q_empty),
		.head      (q_head)
	);

	cgsad_back #(
		.REFERENCE_SLOTS (REFERENCE_SLOTS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.q_empty (q_empty),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.res     (res)
	);

endmodule
`default_nettype wire

### src/cgsad_ram.sv
// cgsad_ram: generic single-port ram with registered read
// no dependencies
`default_nettype none
module cgsad_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 16384,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] addr,
	input  wire logic [WIDTH-1:0]  wdata,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule
`default_nettype wire

### src/cgsad_cfg.sv
// cgsad_cfg: apb register file for thresholds, region size and reference setup
// depends on cgsad_pkg
`default_nettype none
module cgsad_cfg import cgsad_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [CFG_AW-1:0] paddr,
	input  wire logic [CFG_DW-1:0] pwdata,
	output logic      [CFG_DW-1:0] prdata,
	output logic                   pready,
	output cgsad_cfg_t             cfg
);

	cgsad_cfg_t cfg_q;
	cfg_reg_t   reg_sel;
	logic       wr_en;

	assign reg_sel = cfg_reg_t'(paddr[CFG_AW-1:2]);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bin_thr    <= BIN_THR_RST;
			cfg_q.cov_thr    <= COV_THR_RST;
			cfg_q.region     <= REGION_RST;
			cfg_q.ref_count  <= REF_COUNT_RST;
			cfg_q.valid_mask <= VALID_MASK_RST;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_BIN_THR:    cfg_q.bin_thr    <= pwdata[PIX_W-1:0];
				REG_COV_THR:    cfg_q.cov_thr    <= pwdata[PCT_W-1:0];
				REG_REGION:     cfg_q.region     <= pwdata[CNT_W-1:0];
				REG_REF_COUNT:  cfg_q.ref_count  <= pwdata[RCNT_W-1:0];
				REG_VALID_MASK: cfg_q.valid_mask <= pwdata[MASK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_sel)
			REG_BIN_THR:    prdata = CFG_DW'(cfg_q.bin_thr);
			REG_COV_THR:    prdata = CFG_DW'(cfg_q.cov_thr);
			REG_REGION:     prdata = CFG_DW'(cfg_q.region);
			REG_REF_COUNT:  prdata = CFG_DW'(cfg_q.ref_count);
			REG_VALID_MASK: prdata = CFG_DW'(cfg_q.valid_mask);
			default:        prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

### src/cgsad_front.sv
// cgsad_front: accepts pixel beats, loads the reference store, accumulates
// white count and per-reference sad; pushes a frame summary at the last pixel
// depends on cgsad_pkg, cgsad_pix_if, cgsad_ram
`default_nettype none
module cgsad_front import cgsad_pkg::*; #(
	parameter int REGION_MAX_PIXELS = 16384,
	parameter int REFERENCE_SLOTS   = 4
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	cgsad_pix_if.sink   pix,
	input  wire cgsad_cfg_t cfg,
	input  wire logic   q_pop,
	output logic        q_push,
	output logic [REFERENCE_SLOTS*SUM_W+CNT_W-1:0] q_data
);

	localparam int ADDR_W = (REGION_MAX_PIXELS > 1) ? $clog2(REGION_MAX_PIXELS) : 1;

	logic              accept;
	logic              is_frame;
	logic              in_range;
	logic              sel_ok;
	logic [ADDR_W-1:0] addr;
	logic              push_credit;
	logic [QCNT_W-1:0] pend_q;

	logic             frm_s1;
	logic             last_s1;
	logic             inr_s1;
	logic             white_s1;
	logic [PIX_W-1:0] pix_s1;

	logic [PIX_W-1:0] rdata  [REFERENCE_SLOTS];
	logic [PIX_W-1:0] ref_v  [REFERENCE_SLOTS];
	logic [PIX_W-1:0] dif    [REFERENCE_SLOTS];
	logic [SUM_W:0]   sum_w  [REFERENCE_SLOTS];
	logic [SUM_W-1:0] sum_nx [REFERENCE_SLOTS];
	logic [SUM_W-1:0] sum_q  [REFERENCE_SLOTS];
	logic [CNT_W-1:0] cnt_nx;
	logic [CNT_W-1:0] cnt_q;

	assign pix.ready   = pend_q < QCNT_W'(QDEPTH);
	assign accept      = pix.valid && pix.ready;
	assign is_frame    = pix.kind == KIND_FRAME;
	assign in_range    = 32'(pix.pixel_index) < 32'(REGION_MAX_PIXELS);
	assign sel_ok      = 32'(pix.reference_select) < 32'(REFERENCE_SLOTS);
	assign addr        = ADDR_W'(pix.pixel_index);
	assign push_credit = accept && is_frame && pix.last_pixel;

	for (genvar r = 0; r < REFERENCE_SLOTS; r++) begin : g_slot
		logic ram_en;
		assign ram_en = accept && in_range &&
			(is_frame || (sel_ok && (32'(pix.reference_select) == r)));
		cgsad_ram #(
			.WIDTH (PIX_W),
			.DEPTH (REGION_MAX_PIXELS)
		) u_ref_ram (
			.clk   (clk),
			.en    (ram_en),
			.we    (pix.kind == KIND_LOAD),
			.addr  (addr),
			.wdata (pix.pixel_value),
			.rdata (rdata[r])
		);
	end

	// results in flight plus queued entries never exceed the queue depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (push_credit && !q_pop) begin
			pend_q <= pend_q + QCNT_W'(1);
		end else if (!push_credit && q_pop) begin
			pend_q <= pend_q - QCNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frm_s1 <= 1'b0;
		end else begin
			frm_s1 <= accept && is_frame;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1  <= pix.last_pixel;
			inr_s1   <= in_range;
			white_s1 <= pix.pixel_value > cfg.bin_thr;
			pix_s1   <= pix.pixel_value;
		end
	end

	always_comb begin
		for (int k = 0; k < REFERENCE_SLOTS; k++) begin
			ref_v[k]  = inr_s1 ? rdata[k] : '0;
			dif[k]    = (pix_s1 > ref_v[k]) ? pix_s1 - ref_v[k] : ref_v[k] - pix_s1;
			sum_w[k]  = {1'b0, sum_q[k]} + (SUM_W+1)'(dif[k]);
			sum_nx[k] = sum_w[k][SUM_W] ? SUM_MAX : sum_w[k][SUM_W-1:0];
		end
		cnt_nx = (white_s1 && (cnt_q != COUNT_MAX)) ? cnt_q + CNT_W'(1) : cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			for (int k = 0; k < REFERENCE_SLOTS; k++) begin
				sum_q[k] <= '0;
			end
		end else if (frm_s1) begin
			cnt_q <= last_s1 ? '0 : cnt_nx;
			for (int k = 0; k < REFERENCE_SLOTS; k++) begin
				sum_q[k] <= last_s1 ? '0 : sum_nx[k];
			end
		end
	end

	assign q_push = frm_s1 && last_s1;

	always_comb begin
		q_data = '0;
		for (int k = 0; k < REFERENCE_SLOTS; k++) begin
			q_data[k*SUM_W +: SUM_W] = sum_nx[k];
		end
		q_data[REFERENCE_SLOTS*SUM_W +: CNT_W] = cnt_nx;
	end

endmodule
`default_nettype wire

### src/cgsad_queue.sv
// cgsad_queue: short fifo of frame summaries between front and back
// depends on cgsad_pkg
`default_nettype none
module cgsad_queue import cgsad_pkg::*; #(
	parameter int WIDTH = 103
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	input  wire logic             pop,
	output logic                  empty,
	output logic      [WIDTH-1:0] head
);

	logic [WIDTH-1:0]  entry_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign empty = cnt_q == '0;
	assign head  = entry_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rptr_q <= rptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (!push && pop) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

### src/cgsad_back.sv
// cgsad_back: registered minimum tree over reference sums, coverage compare
// and result output register
// depends on cgsad_pkg, cgsad_res_if
`default_nettype none
module cgsad_back import cgsad_pkg::*; #(
	parameter int REFERENCE_SLOTS = 4
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire cgsad_cfg_t cfg,
	input  wire logic   q_empty,
	input  wire logic [REFERENCE_SLOTS*SUM_W+CNT_W-1:0] q_head,
	output logic        q_pop,
	cgsad_res_if.source res
);

	localparam int LV = (REFERENCE_SLOTS > 1) ? $clog2(REFERENCE_SLOTS) : 0;
	localparam int P  = 1 << LV;
	localparam int IW = (LV > 0) ? LV : 1;
	localparam int XW = (IW > 3) ? IW : 3;

	logic adv;

	// heap order: node 1 is the root, leaves are P..2P-1
	logic [SUM_W-1:0] node_sum_q [1:2*P-1];
	logic [IW-1:0]    node_idx_q [1:2*P-1];
	logic             node_en_q  [1:2*P-1];

	logic              vld_q [LV+1];
	logic [CNT_W-1:0]  wc_q  [LV+1];
	logic [PROD_W-1:0] pw_q  [LV+1];
	logic [PROD_W-1:0] pt_q  [LV+1];

	logic             out_vld_q;
	logic             out_det_q;
	logic [CNT_W-1:0] out_wc_q;
	logic [SEL_W-1:0] out_ref_q;
	logic [SUM_W-1:0] out_score_q;
	logic             out_pos_q;

	logic [XW-1:0] root_idx;
	logic          root_det;

	assign adv   = !out_vld_q || res.ready;
	assign q_pop = adv && !q_empty;

	for (genvar k = 0; k < P; k++) begin : g_leaf
		always_ff @(posedge clk) begin
			if (adv) begin
				node_idx_q[P+k] <= IW'(k);
				if (k < REFERENCE_SLOTS) begin
					node_sum_q[P+k] <= q_head[k*SUM_W +: SUM_W];
					node_en_q[P+k]  <= slot_enabled(k, cfg.ref_count);
				end else begin
					node_sum_q[P+k] <= '0;
					node_en_q[P+k]  <= 1'b0;
				end
			end
		end
	end

	// lower index sits on the left and wins on equal sums
	for (genvar i = 1; i < P; i++) begin : g_node
		logic pick_l;
		assign pick_l = node_en_q[2*i] &&
			(!node_en_q[2*i+1] || (node_sum_q[2*i] <= node_sum_q[2*i+1]));
		always_ff @(posedge clk) begin
			if (adv) begin
				node_sum_q[i] <= pick_l ? node_sum_q[2*i] : node_sum_q[2*i+1];
				node_idx_q[i] <= pick_l ? node_idx_q[2*i] : node_idx_q[2*i+1];
				node_en_q[i]  <= node_en_q[2*i] || node_en_q[2*i+1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l <= LV; l++) begin
				vld_q[l] <= 1'b0;
			end
		end else if (adv) begin
			vld_q[0] <= !q_empty;
			for (int l = 1; l <= LV; l++) begin
				vld_q[l] <= vld_q[l-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wc_q[0] <= q_head[REFERENCE_SLOTS*SUM_W +: CNT_W];
			pw_q[0] <= PROD_W'(q_head[REFERENCE_SLOTS*SUM_W +: CNT_W]) * PROD_W'(PCT_FULL);
			pt_q[0] <= PROD_W'(cfg.cov_thr) * PROD_W'(cfg.region);
			for (int l = 1; l <= LV; l++) begin
				wc_q[l] <= wc_q[l-1];
				pw_q[l] <= pw_q[l-1];
				pt_q[l] <= pt_q[l-1];
			end
		end
	end

	assign root_idx = XW'(node_idx_q[1]);
	assign root_det = pw_q[LV] > pt_q[LV];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_q[LV];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_det_q   <= root_det;
			out_wc_q    <= wc_q[LV];
			out_ref_q   <= root_idx[SEL_W-1:0];
			out_score_q <= node_sum_q[1];
			out_pos_q   <= root_det && (root_idx < XW'(MASK_W)) &&
				cfg.valid_mask[root_idx[SEL_W-1:0]];
		end
	end

	assign res.valid          = out_vld_q;
	assign res.detected       = out_det_q;
	assign res.white_count    = out_wc_q;
	assign res.best_reference = out_ref_q;
	assign res.best_score     = out_score_q;
	assign res.valid_position = out_pos_q;

endmodule
`default_nettype wire

### tb/coverage_gate_and_sad_template_match_tb.sv
// coverage_gate_and_sad_template_match_tb: self-checking bench for the coverage gate and sad
// template match block; predicts each frame result and checks every result beat
// depends on cgsad_pkg, cgsad_pix_if, cgsad_res_if and the block's top level
`default_nettype none
module coverage_gate_and_sad_template_match_tb;
	import cgsad_pkg::*;

	localparam int REF_SLOTS      = 4;
	localparam int RESULT_LATENCY = 5;
	localparam int PHASES         = 10;
	localparam int PHASE_ITEMS    = 74;
	localparam int HOLD_CYCLES    = 300;

	typedef struct packed {
		logic             kind;
		logic [SEL_W-1:0] sel;
		logic [IDX_W-1:0] idx;
		logic [PIX_W-1:0] value;
		logic             last;
	} pixel_beat_t;

	typedef struct packed {
		logic             detected;
		logic [CNT_W-1:0] white_count;
		logic [SEL_W-1:0] best_ref;
		logic [SUM_W-1:0] best_score;
		logic             valid_pos;
	} frame_result_t;

	class match_scoreboard;
		logic [PIX_W-1:0] ref_pix [REF_SLOTS][1 << IDX_W];
		int unsigned      sad [REF_SLOTS];
		int unsigned      whites;
		cgsad_cfg_t       cfg;
		frame_result_t    frame_q [$];
		int unsigned      failures;

		function new();
			cfg = '{BIN_THR_RST, COV_THR_RST, REGION_RST, REF_COUNT_RST, VALID_MASK_RST};
			whites = 0;
			failures = 0;
			foreach (sad[i]) sad[i] = 0;
		endfunction

		function void set_reg(cfg_reg_t r, logic [CFG_DW-1:0] v);
			case (r)
				REG_BIN_THR:    cfg.bin_thr = v[PIX_W-1:0];
				REG_COV_THR:    cfg.cov_thr = v[PCT_W-1:0];
				REG_REGION:     cfg.region = v[CNT_W-1:0];
				REG_REF_COUNT:  cfg.ref_count = v[RCNT_W-1:0];
				REG_VALID_MASK: cfg.valid_mask = v[MASK_W-1:0];
				default: ;
			endcase
		endfunction

		function int unsigned pending();
			return frame_q.size();
		endfunction

		function void note_pixel(pixel_beat_t b);
			int unsigned   n, d, s, best;
			int unsigned   rv;
			frame_result_t r;
			if (b.kind == KIND_LOAD) begin
				ref_pix[b.sel][b.idx] = b.value;
				return;
			end
			if (b.value > cfg.bin_thr && whites < int'(COUNT_MAX))
				whites++;
			if (cfg.ref_count == 0)
				n = 1;
			else if (cfg.ref_count > REF_SLOTS)
				n = REF_SLOTS;
			else
				n = cfg.ref_count;
			for (int i = 0; i < n; i++) begin
				rv = ref_pix[i][b.idx];
				d = (int'(b.value) > rv) ? int'(b.value) - rv : rv - int'(b.value);
				s = sad[i] + d;
				sad[i] = (s > int'(SUM_MAX)) ? int'(SUM_MAX) : s;
			end
			if (!b.last)
				return;
			best = 0;
			for (int i = 1; i < n; i++)
				if (sad[i] < sad[best])
					best = i;
			r.detected = (64'(whites) * 64'(PCT_FULL) > 64'(cfg.cov_thr) * 64'(cfg.region));
			r.white_count = CNT_W'(whites);
			r.best_ref = SEL_W'(best);
			r.best_score = SUM_W'(sad[best]);
			r.valid_pos = r.detected & cfg.valid_mask[best];
			frame_q = {frame_q, r};
			foreach (sad[i]) sad[i] = 0;
			whites = 0;
		endfunction

		function void check_result(frame_result_t got);
			frame_result_t want;
			if (frame_q.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("result beat with no frame pending: white=%0d score=%0d",
						got.white_count, got.best_score);
				return;
			end
			want = frame_q.pop_front();
			if (got.detected !== want.detected || got.white_count !== want.white_count ||
					got.best_ref !== want.best_ref || got.best_score !== want.best_score ||
					got.valid_pos !== want.valid_pos) begin
				failures++;
				if (failures <= 10)
					$display({"frame result mismatch: expected det=%0b white=%0d best=%0d ",
						"score=%0d pos=%0b, got det=%0b white=%0d best=%0d score=%0d pos=%0b"},
						want.detected, want.white_count, want.best_ref, want.best_score,
						want.valid_pos, got.detected, got.white_count, got.best_ref,
						got.best_score, got.valid_pos);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [CFG_DW-1:0] pwdata;
	logic [CFG_DW-1:0] prdata;
	logic              pready;

	cgsad_pix_if pix ();
	cgsad_res_if res ();

	match_scoreboard   sb;
	int unsigned       src_idle_pct;
	int unsigned       snk_idle_pct;
	bit                hold_request;
	logic [IDX_W-1:0]  loaded_columns [$];
	cgsad_cfg_t        fixed_cfg [5];

	coverage_gate_and_sad_template_match uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pix     (pix),
		.res     (res),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	task automatic send_pixel(input pixel_beat_t b);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			pix.valid <= 1'b0;
			@(posedge clk);
		end
		pix.valid <= 1'b1;
		pix.kind <= b.kind;
		pix.reference_select <= b.sel;
		pix.pixel_index <= b.idx;
		pix.pixel_value <= b.value;
		pix.last_pixel <= b.last;
		@(posedge clk);
		while (!pix.ready)
			@(posedge clk);
		sb.note_pixel(b);
	endtask

	task automatic send_load(input logic [SEL_W-1:0] sel, input logic [IDX_W-1:0] idx,
			input logic [PIX_W-1:0] value, input logic last);
		send_pixel('{KIND_LOAD, sel, idx, value, last});
	endtask

	task automatic send_frame_pixel(input logic [IDX_W-1:0] idx, input logic [PIX_W-1:0] value,
			input logic last);
		send_pixel('{KIND_FRAME, SEL_W'($urandom_range(0, 3)), idx, value, last});
	endtask

	task automatic load_column(input logic [IDX_W-1:0] idx);
		for (int s = 0; s < REF_SLOTS; s++)
			send_load(SEL_W'(s), idx, PIX_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		loaded_columns = {loaded_columns, idx};
	endtask

	function automatic logic [PIX_W-1:0] rand_value();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return sb.cfg.bin_thr;
			3: return sb.cfg.bin_thr + 1'b1;
			default: return PIX_W'($urandom_range(0, 255));
		endcase
	endfunction

	// frame pixels only touch columns loaded in every slot
	task automatic send_frame(input int unsigned len);
		for (int unsigned k = 1; k <= len; k++)
			send_frame_pixel(loaded_columns[$urandom_range(0, loaded_columns.size() - 1)],
				rand_value(), k == len);
	endtask

	task automatic settle();
		pix.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (RESULT_LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_register(input cfg_reg_t r, input logic [CFG_DW-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CFG_AW'(4 * int'(r));
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		sb.set_reg(r, v);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_settings(input cgsad_cfg_t c);
		write_register(REG_BIN_THR, CFG_DW'(c.bin_thr));
		write_register(REG_COV_THR, CFG_DW'(c.cov_thr));
		write_register(REG_REGION, CFG_DW'(c.region));
		write_register(REG_REF_COUNT, CFG_DW'(c.ref_count));
		write_register(REG_VALID_MASK, CFG_DW'(c.valid_mask));
	endtask

	function automatic cgsad_cfg_t random_settings();
		cgsad_cfg_t c;
		c.bin_thr = PIX_W'($urandom_range(0, 255));
		c.cov_thr = PCT_W'($urandom_range(0, 2047));
		c.region = ($urandom_range(0, 1) != 0) ? CNT_W'($urandom_range(0, 24)) :
			CNT_W'($urandom_range(0, 32767));
		c.ref_count = RCNT_W'($urandom_range(0, 7));
		c.valid_mask = MASK_W'($urandom_range(0, 15));
		return c;
	endfunction

	task automatic random_traffic(input int unsigned items);
		int unsigned sent;
		int unsigned pick;
		int unsigned len;
		sent = 0;
		while (sent < items) begin
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				len = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 8) : $urandom_range(9, 40);
				send_frame(len);
				sent += len;
			end else if (pick < 80) begin
				send_load(SEL_W'($urandom_range(0, 3)),
					loaded_columns[$urandom_range(0, loaded_columns.size() - 1)],
					PIX_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				sent += 1;
			end else if (pick < 90) begin
				load_column(IDX_W'($urandom_range(0, 16383)));
				sent += REF_SLOTS;
			end else begin
				// stray load with the frame end flag set
				send_load(SEL_W'($urandom_range(0, 3)), IDX_W'($urandom_range(0, 16383)),
					PIX_W'($urandom_range(0, 255)), 1'b1);
				sent += 1;
			end
		end
	endtask

	// result sink with random stalls and one long hold-off
	initial begin : result_sink
		int unsigned hold_left;
		bit          hold_served;
		hold_left = 0;
		hold_served = 0;
		res.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				hold_left--;
				res.ready <= 1'b0;
			end else if (hold_request && !hold_served) begin
				hold_served = 1;
				hold_left = HOLD_CYCLES;
				res.ready <= 1'b0;
			end else begin
				res.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
			end
		end
	end

	always @(posedge clk) begin : result_monitor
		frame_result_t seen;
		if (arst_n === 1'b1 && res.valid === 1'b1 && res.ready === 1'b1) begin
			seen = '{res.detected, res.white_count, res.best_reference, res.best_score,
				res.valid_position};
			sb.check_result(seen);
		end
	end

	initial begin : stimulus
		sb = new();
		src_idle_pct = 6;
		snk_idle_pct = 87;
		hold_request = 0;
		fixed_cfg[0] = '{8'd0, 11'd0, 15'd0, 3'd0, 4'd15};
		fixed_cfg[1] = '{8'd255, 11'd2047, 15'd32767, 3'd7, 4'd0};
		fixed_cfg[2] = '{8'd128, 11'd1600, 15'd1, 3'd1, 4'd1};
		fixed_cfg[3] = '{8'd100, 11'd800, 15'd8, 3'd2, 4'd5};
		fixed_cfg[4] = '{8'd60, 11'd400, 15'd16, 3'd3, 4'd10};
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		pix.valid <= 1'b0;
		pix.kind <= KIND_LOAD;
		pix.reference_select <= '0;
		pix.pixel_index <= '0;
		pix.pixel_value <= '0;
		pix.last_pixel <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reference columns at the index extremes and every one-hot index
		load_column('0);
		load_column('1);
		for (int b = 0; b < IDX_W; b++)
			load_column(IDX_W'(1) << b);
		repeat (8) load_column(IDX_W'($urandom_range(0, 16383)));

		// tie between slots 1 and 2, lowest index wins
		send_load(2'd0, '0, 8'd200, 1'b0);
		send_load(2'd1, '0, 8'd100, 1'b0);
		send_load(2'd2, '0, 8'd100, 1'b1);
		send_load(2'd3, '0, 8'd255, 1'b0);
		send_frame_pixel('0, 8'd100, 1'b1);
		// threshold edges and full-scale pixels
		send_frame_pixel('1, 8'd255, 1'b0);
		send_frame_pixel('1, 8'd0, 1'b0);
		send_frame_pixel('0, 8'd128, 1'b0);
		send_frame_pixel('0, 8'd127, 1'b1);
		send_load(2'd3, '1, 8'd0, 1'b1);
		send_frame_pixel(IDX_W'(8192), 8'd0, 1'b1);
		send_frame_pixel('1, 8'd255, 1'b1);
		settle();

		for (int p = 0; p < PHASES; p++) begin
			if (p < 4) begin
				src_idle_pct = 6;
				snk_idle_pct = 87;
			end else if (p < 7) begin
				src_idle_pct = 87;
				snk_idle_pct = 6;
			end else begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			if (p >= 1 && p <= 5)
				apply_settings(fixed_cfg[p - 1]);
			else if (p > 5)
				apply_settings(random_settings());
			if (p == 8) begin
				// result side stalls while single-pixel frames keep coming
				hold_request = 1;
				repeat (16) send_frame(1);
			end
			random_traffic(PHASE_ITEMS);
			settle();
		end

		if (sb.failures == 0 && sb.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
`default_nettype wire
